FILE: hdl/vnvt_pkg.sv
// Constants, types and helpers shared by the voxel noise threshold block.
package vnvt_pkg;

	localparam int FRAC_BITS  = 24;
	localparam int PROD_FRAC  = 28;
	localparam int CELL_BITS  = 24;
	localparam int PROD_BITS  = 53;
	localparam int LANES      = 8;

	localparam logic [63:0] HASH_X = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] HASH_Y = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] HASH_Z = 64'h165667B19E3779F9;
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_M2 = 64'h94D049BB133111EB;

	localparam logic [FRAC_BITS:0] FADE_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [7:0]         IRON_INDEX = 8'd11;

	localparam logic [19:0] FREQ_RESET   = 20'd5461;
	localparam logic [24:0] THRESH_RESET = 25'd1342177;
	localparam logic [7:0]  TARGET_RESET = 8'd1;

	typedef enum logic [2:0] {
		REG_FEATURE_MODE    = 3'd0,
		REG_NOISE_SEED      = 3'd1,
		REG_NOISE_FREQUENCY = 3'd2,
		REG_NOISE_THRESHOLD = 3'd3,
		REG_TARGET_MATERIAL = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic       solid;
		logic [7:0] material;
	} side_t;

	typedef struct packed {
		logic [FRAC_BITS:0] x;
		logic [FRAC_BITS:0] y;
		logic [FRAC_BITS:0] z;
	} fade_t;

	typedef struct packed {
		logic                 neg;
		logic [FRAC_BITS-1:0] base;
		logic [FRAC_BITS-1:0] mag;
	} lerp_t;

	function automatic lerp_t lerp_prep(logic [FRAC_BITS-1:0] a, logic [FRAC_BITS-1:0] b);
		lerp_t r;
		r.neg  = b < a;
		r.base = a;
		r.mag  = r.neg ? a - b : b - a;
		return r;
	endfunction

	function automatic logic [FRAC_BITS-1:0] lerp_done(lerp_t p, logic [FRAC_BITS:0] t);
		logic [2*FRAC_BITS:0] prod;
		logic [FRAC_BITS-1:0] step;
		prod = (2*FRAC_BITS + 1)'(p.mag) * (2*FRAC_BITS + 1)'(t);
		step = prod[2*FRAC_BITS-1:FRAC_BITS];
		return p.neg ? p.base - step : p.base + step;
	endfunction

endpackage

FILE: hdl/vnvt_mix.sv
// Pipelined splitmix64 finalizer for one lattice corner, top 24 bits out.
module vnvt_mix import vnvt_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [63:0]          h,
	output logic [FRAC_BITS-1:0] value
);

	logic [63:0] z0, z1, z2;
	logic [63:0] z_s1, ll_s2, z_s3, ll_s4;
	logic [31:0] mid_s2, mid_s4;
	logic [FRAC_BITS-1:0] value_s5;

	always_comb begin
		z0 = h + GOLDEN;
		z1 = ll_s2 + {mid_s2, 32'd0};
		z2 = ll_s4 + {mid_s4, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1     <= z0 ^ (z0 >> 30);
			ll_s2    <= 64'(z_s1[31:0]) * 64'(MIX_M1[31:0]);
			mid_s2   <= 32'(z_s1[31:0] * MIX_M1[63:32]) + 32'(z_s1[63:32] * MIX_M1[31:0]);
			z_s3     <= z1 ^ (z1 >> 27);
			ll_s4    <= 64'(z_s3[31:0]) * 64'(MIX_M2[31:0]);
			mid_s4   <= 32'(z_s3[31:0] * MIX_M2[63:32]) + 32'(z_s3[63:32] * MIX_M2[31:0]);
			value_s5 <= z2[63:40];
		end
	end

	assign value = value_s5;

endmodule

FILE: hdl/value_noise_voxel_threshold.sv
// Top level: 3D value noise per voxel, compared to a threshold to carve or place ore.
//
// Input channel in_valid/in_ready carries one voxel: pos_x/y/z (signed Q20.12),
// in_solid and in_material. Output channel out_valid/out_ready returns
// out_solid, out_material, changed and noise_value (Q0.24) for that voxel.
// Registers are written through cfg_we/cfg_addr/cfg_wdata, only while idle; this
// binds the user, as the block itself does not enforce it.
//
// Throughput is one voxel per cycle unless the receiver stalls; the splitmix64
// multiplies, cut into 32-bit partial products, set the pipeline depth.
//
// Reset clears all stage valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready drops; no item is lost or repeated.
module value_noise_voxel_threshold import vnvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [63:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic                 in_solid,
	input  logic [7:0]           in_material,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_solid,
	output logic [7:0]           out_material,
	output logic                 changed,
	output logic [FRAC_BITS-1:0] noise_value
);

	localparam int LAST = 16;

	logic        mode_q;
	logic [63:0] seed_q;
	logic [19:0] freq_q;
	logic [24:0] thresh_q;
	logic [7:0]  target_q;

	logic            en;
	logic [LAST:1]   valid_s;
	side_t           side_s [1:LAST];
	fade_t           fade_s [4:14];

	logic signed [PROD_BITS-1:0] p_s1 [3];
	logic [FRAC_BITS-1:0]        t_s2 [3];
	logic [FRAC_BITS-1:0]        t2_s2 [3];
	logic signed [56:0]          cmlo_s2 [3];
	logic [31:0]                 cmhi_s2 [3];
	logic [FRAC_BITS-1:0]        t3_s3 [3];
	logic [27:0]                 poly_s3 [3];
	logic [63:0]                 terma_s3 [3];
	logic [63:0]                 termb_s3 [3];
	logic [63:0]                 h_s4 [LANES];
	logic [FRAC_BITS:0]          fd [3];
	logic [FRAC_BITS-1:0]        corner [LANES];
	lerp_t                       lx_s10 [4];
	logic [FRAC_BITS-1:0]        x_s11 [4];
	lerp_t                       ly_s12 [2];
	logic [FRAC_BITS-1:0]        y_s13 [2];
	lerp_t                       lz_s14;
	logic [FRAC_BITS-1:0]        noise_s15;
	logic                        solid_s16;
	logic [7:0]                  material_s16;
	logic                        changed_s16;
	logic [FRAC_BITS-1:0]        noise_s16;

	logic signed [31:0]          pos [3];
	logic [63:0]                 hash_k [3];
	logic                        below;

	assign pos    = '{pos_x, pos_y, pos_z};
	assign hash_k = '{HASH_X, HASH_Y, HASH_Z};
	assign en       = !valid_s[LAST] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			seed_q   <= 64'd0;
			freq_q   <= FREQ_RESET;
			thresh_q <= THRESH_RESET;
			target_q <= TARGET_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_addr))
				REG_FEATURE_MODE:    mode_q   <= cfg_wdata[0];
				REG_NOISE_SEED:      seed_q   <= cfg_wdata;
				REG_NOISE_FREQUENCY: freq_q   <= cfg_wdata[19:0];
				REG_NOISE_THRESHOLD: thresh_q <= cfg_wdata[24:0];
				REG_TARGET_MATERIAL: target_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[LAST-1:1], in_valid};
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [51:0] r;
			r     = 52'(t3_s3[a]) * 52'(poly_s3[a]);
			fd[a] = (r[51:FRAC_BITS] > 28'(FADE_ONE)) ? FADE_ONE : r[2*FRAC_BITS:FRAC_BITS];
		end
	end

	assign below = {1'b0, noise_s15} < thresh_q;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{solid: in_solid, material: in_material};
			for (int k = 2; k <= LAST; k++) begin
				side_s[k] <= side_s[k-1];
			end
			fade_s[4] <= '{x: fd[0], y: fd[1], z: fd[2]};
			for (int k = 5; k <= 14; k++) begin
				fade_s[k] <= fade_s[k-1];
			end
			for (int a = 0; a < 3; a++) begin
				logic [2*FRAC_BITS-1:0] sq;
				logic [2*FRAC_BITS-1:0] cu;
				logic [27:0]            pp;
				logic [27:0]            pn;
				p_s1[a]     <= pos[a] * $signed({1'b0, freq_q});
				t_s2[a]     <= p_s1[a][PROD_FRAC-1:PROD_FRAC-FRAC_BITS];
				sq          = (2*FRAC_BITS)'(p_s1[a][PROD_FRAC-1:PROD_FRAC-FRAC_BITS])
					* (2*FRAC_BITS)'(p_s1[a][PROD_FRAC-1:PROD_FRAC-FRAC_BITS]);
				t2_s2[a]    <= sq[2*FRAC_BITS-1:FRAC_BITS];
				cmlo_s2[a]  <= $signed(p_s1[a][51:PROD_FRAC])
					* $signed({1'b0, hash_k[a][31:0]});
				cmhi_s2[a]  <= 32'($signed(p_s1[a][51:PROD_FRAC])
					* $signed({1'b0, hash_k[a][63:32]}));
				cu          = (2*FRAC_BITS)'(t2_s2[a]) * (2*FRAC_BITS)'(t_s2[a]);
				t3_s3[a]    <= cu[2*FRAC_BITS-1:FRAC_BITS];
				pp          = 28'(6) * 28'(t2_s2[a]) + (28'(10) << FRAC_BITS);
				pn          = 28'(15) * 28'(t_s2[a]);
				poly_s3[a]  <= (pp > pn) ? pp - pn : 28'd0;
				terma_s3[a] <= 64'(cmlo_s2[a]) + {cmhi_s2[a], 32'd0};
				termb_s3[a] <= 64'(cmlo_s2[a]) + {cmhi_s2[a], 32'd0} + hash_k[a];
			end
			for (int i = 0; i < LANES; i++) begin
				h_s4[i] <= seed_q
					^ (i[0] ? termb_s3[0] : terma_s3[0])
					^ (i[1] ? termb_s3[1] : terma_s3[1])
					^ (i[2] ? termb_s3[2] : terma_s3[2]);
			end
			for (int j = 0; j < 4; j++) begin
				lx_s10[j] <= lerp_prep(corner[2*j], corner[2*j+1]);
				x_s11[j]  <= lerp_done(lx_s10[j], fade_s[10].x);
			end
			for (int j = 0; j < 2; j++) begin
				ly_s12[j] <= lerp_prep(x_s11[2*j], x_s11[2*j+1]);
				y_s13[j]  <= lerp_done(ly_s12[j], fade_s[12].y);
			end
			lz_s14    <= lerp_prep(y_s13[0], y_s13[1]);
			noise_s15 <= lerp_done(lz_s14, fade_s[14].z);
			noise_s16 <= noise_s15;
			if (side_s[15].solid && below && !mode_q) begin
				solid_s16    <= 1'b0;
				material_s16 <= 8'd0;
				changed_s16  <= 1'b1;
			end else if (side_s[15].solid && below && side_s[15].material == target_q) begin
				solid_s16    <= side_s[15].solid;
				material_s16 <= IRON_INDEX;
				changed_s16  <= 1'b1;
			end else begin
				solid_s16    <= side_s[15].solid;
				material_s16 <= side_s[15].material;
				changed_s16  <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_mix
		vnvt_mix u_mix (
			.clk   (clk),
			.en    (en),
			.h     (h_s4[g]),
			.value (corner[g])
		);
	end

	assign out_valid    = valid_s[LAST];
	assign out_solid    = solid_s16;
	assign out_material = material_s16;
	assign changed      = changed_s16;
	assign noise_value  = noise_s16;

endmodule
